// ===== rtl/rte_pkg.sv =====
package rte_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int DIST_W      = 16;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    // Stream payload widths (rounded up to whole bytes)
    localparam int IN_BITS   = FUNC_W + 2 * ADDR_W + DIST_W + IDX_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + CNT_W + 2 * ADDR_W + DIST_W + CNT_W + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND   = 3'd0,
        FUNC_REMOVE   = 3'd1,
        FUNC_FIND     = 3'd2,
        FUNC_HAS_HOP  = 3'd3,
        FUNC_HAS_DIST = 3'd4,
        FUNC_READ     = 3'd5
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    // Which entry field a cell compares against the key
    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_DEST = 2'd1,
        KEY_HOP  = 2'd2,
        KEY_DIST = 2'd3
    } key_sel_t;

    // Controller states
    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_RESOLVE = 1'b1
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [DIST_W-1:0] distance;
    } route_t;

    // Per-cell control from the controller
    typedef struct packed {
        logic              cmp_en;
        key_sel_t          key_sel;
        logic [ADDR_W-1:0] key;
        logic              load_en;
        logic              shift_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/rte_cell.sv =====
module rte_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rte_pkg::cell_ctrl_t ctrl,
    input  rte_pkg::route_t     load_entry,
    input  rte_pkg::route_t     right_entry,
    output rte_pkg::route_t     entry,
    output logic                hit
);

    rte_pkg::route_t entry_reg;
    logic            hit_reg;
    logic            match;

    // Compare the held entry against the broadcast key
    always_comb
    begin
        case (ctrl.key_sel)
            rte_pkg::KEY_DEST: match = (entry_reg.dest == ctrl.key);
            rte_pkg::KEY_HOP:  match = (entry_reg.hop == ctrl.key);
            rte_pkg::KEY_DIST: match = (entry_reg.distance == ctrl.key[rte_pkg::DIST_W-1:0]);
            default:           match = 1'b0;
        endcase
    end

    // Hold the entry; load on append, take the right neighbour's entry on removal
    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            entry_reg <= load_entry;
        end
        else if (ctrl.shift_en)
        begin
            entry_reg <= right_entry;
        end
    end

    // Register the compare result for the controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            hit_reg <= match;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ===== rtl/routing_table_engine.sv =====
// Routing table engine: an ordered table of up to 16 routes held in a row of cells.
// Command channel s_*: one command per transaction (append, remove by destination,
// find destination, test first hop, test distance, read entry).
// Result channel m_*: exactly one result transaction per command.
// When a command is accepted, every cell compares its entry with the key and
// registers a hit bit. Then, in the resolve state, the lowest hit is picked;
// once the output register is free, the result is loaded into it and the table is
// updated (append writes one cell, removal shifts all later cells down by one).
// The block then returns to idle and only there takes a new command, so a command
// is never taken before the previous one is resolved; the output register decouples
// the two sides, so a command is accepted while the previous result still waits.
// Stall: if the receiver holds m_tready low, the result stays put and the next
// command waits in its resolve cycle until the output register frees up.
// Reset empties the table (entry count zero) and drops any pending result; no
// clearing pass is needed since entries are only read below the entry count.
module routing_table_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: func[3], destination[32], first_hop[32], distance[16],
    // entry_index[4], zero fill
    input  logic [rte_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, from bit 0: found[1], match_index[5], route_destination[32],
    // route_first_hop[32], route_distance[16], entry_count[5], status[2], zero fill
    output logic [rte_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = rte_pkg::TABLE_DEPTH;
    localparam int IW    = rte_pkg::IDX_W;
    localparam int CW    = rte_pkg::CNT_W;
    localparam int AW    = rte_pkg::ADDR_W;
    localparam int DW    = rte_pkg::DIST_W;
    localparam int FW    = rte_pkg::FUNC_W;

    // Input field offsets
    localparam int IN_DEST_LO = FW;
    localparam int IN_HOP_LO  = IN_DEST_LO + AW;
    localparam int IN_DIST_LO = IN_HOP_LO + AW;
    localparam int IN_IDX_LO  = IN_DIST_LO + DW;

    // Unpacked command fields
    logic [FW-1:0] in_func;
    logic [AW-1:0] in_dest;
    logic [AW-1:0] in_hop;
    logic [DW-1:0] in_dist;
    logic [IW-1:0] in_idx;

    assign in_func = s_tdata[FW-1:0];
    assign in_dest = s_tdata[IN_DEST_LO +: AW];
    assign in_hop  = s_tdata[IN_HOP_LO +: AW];
    assign in_dist = s_tdata[IN_DIST_LO +: DW];
    assign in_idx  = s_tdata[IN_IDX_LO +: IW];

    rte_pkg::state_t state_reg;
    rte_pkg::state_t state_next;

    logic [FW-1:0]   func_reg;
    rte_pkg::route_t cmd_entry_reg;
    logic [IW-1:0]   idx_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    logic                        out_valid_reg;
    logic                        found_reg;
    logic [CW-1:0]               mi_reg;
    rte_pkg::route_t             route_reg;
    logic [CW-1:0]               out_count_reg;
    logic [rte_pkg::STATUS_W-1:0] status_reg;

    logic                        accept;
    logic                        resolve;
    logic                        update;
    rte_pkg::key_sel_t           key_sel;
    logic [AW-1:0]               key;

    rte_pkg::cell_ctrl_t         ctrl   [DEPTH];
    rte_pkg::route_t             entries[DEPTH];
    logic [DEPTH-1:0]            hits;
    logic [DEPTH-1:0]            live_hits;

    logic                        any_hit;
    logic [IW-1:0]               hit_pos;
    logic [IW-1:0]               sel_idx;
    rte_pkg::route_t             sel_entry;
    logic                        read_ok;
    logic                        do_append;
    logic                        do_remove;

    logic                        found_c;
    logic [CW-1:0]               mi_c;
    rte_pkg::route_t             route_c;
    logic [rte_pkg::STATUS_W-1:0] status_c;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rte_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rte_pkg::ST_RESOLVE;
                end
            end
            rte_pkg::ST_RESOLVE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = rte_pkg::ST_IDLE;
                end
            end
            default: state_next = rte_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        s_tready = 1'b0;
        resolve  = 1'b0;
        case (state_reg)
            rte_pkg::ST_IDLE:    s_tready = 1'b1;
            rte_pkg::ST_RESOLVE: resolve  = 1'b1;
            default:
            begin
                s_tready = 1'b0;
                resolve  = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign update = resolve && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rte_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the compared field and key for the incoming command
    always_comb
    begin
        case (in_func)
            rte_pkg::FUNC_REMOVE,
            rte_pkg::FUNC_FIND:
            begin
                key_sel = rte_pkg::KEY_DEST;
                key     = in_dest;
            end
            rte_pkg::FUNC_HAS_HOP:
            begin
                key_sel = rte_pkg::KEY_HOP;
                key     = in_hop;
            end
            rte_pkg::FUNC_HAS_DIST:
            begin
                key_sel = rte_pkg::KEY_DIST;
                key     = {{(AW-DW){1'b0}}, in_dist};
            end
            default:
            begin
                key_sel = rte_pkg::KEY_NONE;
                key     = '0;
            end
        endcase
    end

    // Hold the accepted command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg               <= in_func;
            cmd_entry_reg.dest     <= in_dest;
            cmd_entry_reg.hop      <= in_hop;
            cmd_entry_reg.distance <= in_dist;
            idx_reg                <= in_idx;
        end
    end

    // Mask hits to live entries and take the lowest position
    always_comb
    begin
        any_hit = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            live_hits[i] = hits[i] && (CW'(i) < count_reg);
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (live_hits[i])
            begin
                any_hit = 1'b1;
                hit_pos = IW'(i);
            end
        end
    end

    assign read_ok   = ({1'b0, idx_reg} < count_reg);
    assign sel_idx   = (func_reg == rte_pkg::FUNC_READ) ? idx_reg : hit_pos;
    assign sel_entry = entries[sel_idx];

    // Form the result and decide the table update
    always_comb
    begin
        found_c    = 1'b0;
        mi_c       = count_reg;
        route_c    = '0;
        status_c   = rte_pkg::STAT_OK;
        count_next = count_reg;
        do_append  = 1'b0;
        do_remove  = 1'b0;
        case (func_reg)
            rte_pkg::FUNC_APPEND:
            begin
                if (count_reg < CW'(DEPTH))
                begin
                    do_append  = 1'b1;
                    route_c    = cmd_entry_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    status_c = rte_pkg::STAT_FULL;
                end
            end
            rte_pkg::FUNC_REMOVE:
            begin
                if (any_hit)
                begin
                    do_remove  = 1'b1;
                    found_c    = 1'b1;
                    mi_c       = {1'b0, hit_pos};
                    route_c    = sel_entry;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_c = rte_pkg::STAT_NOT_FOUND;
                end
            end
            rte_pkg::FUNC_FIND,
            rte_pkg::FUNC_HAS_HOP,
            rte_pkg::FUNC_HAS_DIST:
            begin
                if (any_hit)
                begin
                    found_c = 1'b1;
                    mi_c    = {1'b0, hit_pos};
                    route_c = sel_entry;
                end
                else
                begin
                    status_c = rte_pkg::STAT_NOT_FOUND;
                end
            end
            rte_pkg::FUNC_READ:
            begin
                if (read_ok)
                begin
                    found_c = 1'b1;
                    mi_c    = {1'b0, idx_reg};
                    route_c = sel_entry;
                end
                else
                begin
                    status_c = rte_pkg::STAT_RANGE;
                end
            end
            default:
            begin
                found_c = 1'b0;
            end
        endcase
    end

    // Advance the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (update)
        begin
            count_reg <= count_next;
        end
    end

    // Drive the row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        assign ctrl[g].cmp_en   = accept;
        assign ctrl[g].key_sel  = key_sel;
        assign ctrl[g].key      = key;
        assign ctrl[g].load_en  = update && do_append && (count_reg == CW'(g));
        assign ctrl[g].shift_en = update && do_remove && (CW'(g) >= {1'b0, hit_pos});

        rte_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[g]),
            .load_entry  (cmd_entry_reg),
            .right_entry (entries[(g < DEPTH - 1) ? g + 1 : g]),
            .entry       (entries[g]),
            .hit         (hits[g])
        );
    end

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (update)
        begin
            found_reg     <= found_c;
            mi_reg        <= mi_c;
            route_reg     <= route_c;
            out_count_reg <= count_next;
            status_reg    <= status_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rte_pkg::OUT_DATA_W - rte_pkg::OUT_BITS){1'b0}},
                       status_reg, out_count_reg, route_reg.distance, route_reg.hop,
                       route_reg.dest, mi_reg, found_reg};

endmodule

// ===== rtl/rte_checker.sv =====
module rte_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rte_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int CW      = rte_pkg::CNT_W;
    localparam int MI_LO   = 1;
    localparam int CNT_LO  = MI_LO + CW + 2 * rte_pkg::ADDR_W + rte_pkg::DIST_W;
    localparam int STAT_LO = CNT_LO + CW;

    logic [CW-1:0]                found_mi;
    logic [CW-1:0]                count;
    logic [rte_pkg::STATUS_W-1:0] status;

    assign found_mi = m_tdata[MI_LO +: CW];
    assign count    = m_tdata[CNT_LO +: CW];
    assign status   = m_tdata[STAT_LO +: rte_pkg::STATUS_W];

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One command in flight: no acceptance in the cycle after a transaction
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted back to back");

    // A hit always reports ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> status == rte_pkg::STAT_OK)
        else $error("found with error status");

    // Count and index stay within the table
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> count <= CW'(rte_pkg::TABLE_DEPTH) && found_mi <= count)
        else $error("count or index out of range");

endmodule

bind routing_table_engine rte_checker u_rte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
